/* sv/mqpq_pkg.sv */
// ----------------------------------------------------------------------------
// mqpq_pkg
// Shared types and constants of the multi-queue max-priority queue.
// ----------------------------------------------------------------------------
package mqpq_pkg;

    localparam int unsigned DefNumQueues   = 16;
    localparam int unsigned DefPoolEntries = 1024;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_RD_WAIT,
        S_DEL_WAIT,
        S_ALLOC_WAIT,
        S_WALK,
        S_CMP,
        S_LINK_NEW,
        S_LINK_PREV,
        S_RESP
    } t_state;

    typedef struct packed {
        logic       init_wr;
        logic       latch;
        logic       rd_head;
        logic       rd_free;
        logic       rd_cur;
        logic       alloc;
        logic       del_commit;
        logic       step;
        logic       wr_link_n;
        logic       link_prev;
        logic       set_res;
        logic [1:0] res_code;
        logic       res_use_key;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       q_valid;
        logic       head_null;
        logic       count_zero;
        logic       cur_null;
        logic       key_ge;
        logic       init_last;
        logic       out_free;
    } t_stat;

endpackage

/* sv/mqpq_datapath.sv */
// ----------------------------------------------------------------------------
// mqpq_datapath
// Node pool memories, queue heads, free list and result registers.
// ----------------------------------------------------------------------------
module mqpq_datapath import mqpq_pkg::*; #(
    parameter int unsigned NUM_QUEUES   = DefNumQueues,
    parameter int unsigned POOL_ENTRIES = DefPoolEntries
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic [1:0]         i_operation,
    input  logic [3:0]         i_queue_index,
    input  logic signed [31:0] i_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_max_value
);

    localparam int unsigned LW = $clog2(POOL_ENTRIES + 1);
    localparam int unsigned AW = $clog2(POOL_ENTRIES);
    localparam int unsigned QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam logic [LW-1:0] NullLink = LW'(POOL_ENTRIES);

    logic [31:0]   mem_key  [POOL_ENTRIES];
    logic [LW-1:0] mem_link [POOL_ENTRIES];

    logic [LW-1:0] r_head [NUM_QUEUES];
    logic [1:0]    r_op;
    logic [3:0]    r_q;
    logic [31:0]   r_value;
    logic [LW-1:0] r_cur;
    logic [LW-1:0] r_prev;
    logic [LW-1:0] r_n;
    logic [LW-1:0] r_free_head;
    logic [LW-1:0] r_free_count;
    logic [AW-1:0] r_init_cnt;
    logic [31:0]   r_rd_key;
    logic [LW-1:0] r_rd_link;
    logic [1:0]    r_res_status;
    logic [31:0]   r_res_max;
    logic          r_out_valid;
    logic [1:0]    r_out_status;
    logic [31:0]   r_out_max;

    logic [QW+3:0] q_ext;
    logic [QW-1:0] q_idx;
    logic [LW-1:0] head_q;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [LW-1:0] wr_data;

    assign q_ext  = {{QW{1'b0}}, r_q};
    assign q_idx  = q_ext[QW-1:0];
    assign head_q = r_head[q_idx];

    always_comb begin
        rd_en   = i_cmd.rd_head | i_cmd.rd_free | i_cmd.rd_cur;
        rd_addr = r_cur[AW-1:0];
        if (i_cmd.rd_head) begin
            rd_addr = head_q[AW-1:0];
        end else if (i_cmd.rd_free) begin
            rd_addr = r_free_head[AW-1:0];
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_init_cnt;
        wr_data = LW'(r_init_cnt) + LW'(1);
        if (i_cmd.init_wr) begin
            wr_en = 1'b1;
        end else if (i_cmd.del_commit) begin
            wr_en   = 1'b1;
            wr_addr = head_q[AW-1:0];
            wr_data = r_free_head;
        end else if (i_cmd.wr_link_n) begin
            wr_en   = 1'b1;
            wr_addr = r_n[AW-1:0];
            wr_data = r_cur;
        end else if (i_cmd.link_prev && (r_prev != NullLink)) begin
            wr_en   = 1'b1;
            wr_addr = r_prev[AW-1:0];
            wr_data = r_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_link[wr_addr] <= wr_data;
        end
        if (i_cmd.alloc) begin
            mem_key[r_n[AW-1:0]] <= r_value;
        end
        if (rd_en) begin
            r_rd_link <= mem_link[rd_addr];
            r_rd_key  <= mem_key[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_head[i] <= NullLink;
            end
            r_free_head  <= '0;
            r_free_count <= NullLink;
            r_init_cnt   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.init_wr) begin
                r_init_cnt <= r_init_cnt + AW'(1);
            end
            if (i_cmd.alloc) begin
                r_free_head  <= r_rd_link;
                r_free_count <= r_free_count - LW'(1);
            end
            if (i_cmd.del_commit) begin
                r_head[q_idx] <= r_rd_link;
                r_free_head   <= head_q;
                r_free_count  <= r_free_count + LW'(1);
            end
            if (i_cmd.link_prev && (r_prev == NullLink)) begin
                r_head[q_idx] <= r_n;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op    <= i_operation;
            r_q     <= i_queue_index;
            r_value <= i_value;
        end
        if (i_cmd.rd_free) begin
            r_n <= r_free_head;
        end
        if (i_cmd.alloc) begin
            r_cur  <= head_q;
            r_prev <= NullLink;
        end
        if (i_cmd.step) begin
            r_prev <= r_cur;
            r_cur  <= r_rd_link;
        end
        if (i_cmd.set_res) begin
            r_res_status <= i_cmd.res_code;
            r_res_max    <= i_cmd.res_use_key ? r_rd_key : '0;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_max    <= r_res_max;
        end
    end

    assign o_stat.op         = r_op;
    assign o_stat.q_valid    = (q_ext < (QW+4)'(NUM_QUEUES));
    assign o_stat.head_null  = (head_q == NullLink);
    assign o_stat.count_zero = (r_free_count == '0);
    assign o_stat.cur_null   = (r_cur == NullLink);
    assign o_stat.key_ge     = ($signed(r_value) >= $signed(r_rd_key));
    assign o_stat.init_last  = (r_init_cnt == AW'(POOL_ENTRIES - 1));
    assign o_stat.out_free   = !r_out_valid || i_ready;

    assign o_valid     = r_out_valid;
    assign o_status    = r_out_status;
    assign o_max_value = r_out_max;

endmodule

/* sv/mqpq_ctrl.sv */
// ----------------------------------------------------------------------------
// mqpq_ctrl
// Sequencer for initialization, insert list walk, read and delete.
// ----------------------------------------------------------------------------
module mqpq_ctrl import mqpq_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (i_stat.init_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                case (i_stat.op)
                    OP_INSERT: begin
                        if (!i_stat.q_valid || i_stat.count_zero) n_state = S_RESP;
                        else n_state = S_ALLOC_WAIT;
                    end
                    OP_READ: begin
                        if (!i_stat.q_valid || i_stat.head_null) n_state = S_RESP;
                        else n_state = S_RD_WAIT;
                    end
                    OP_DELETE: begin
                        if (!i_stat.q_valid || i_stat.head_null) n_state = S_RESP;
                        else n_state = S_DEL_WAIT;
                    end
                    default: n_state = S_RESP;
                endcase
            end
            S_RD_WAIT:    n_state = S_RESP;
            S_DEL_WAIT:   n_state = S_RESP;
            S_ALLOC_WAIT: n_state = S_WALK;
            S_WALK: begin
                if (i_stat.cur_null) n_state = S_LINK_NEW;
                else n_state = S_CMP;
            end
            S_CMP: begin
                if (i_stat.key_ge) n_state = S_LINK_NEW;
                else n_state = S_WALK;
            end
            S_LINK_NEW:  n_state = S_LINK_PREV;
            S_LINK_PREV: n_state = S_RESP;
            S_RESP: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_INIT;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_INIT: o_cmd.init_wr = 1'b1;
            S_IDLE: begin
                o_ready     = 1'b1;
                o_cmd.latch = i_valid;
            end
            S_DISPATCH: begin
                case (i_stat.op)
                    OP_INSERT: begin
                        if (!i_stat.q_valid || i_stat.count_zero) begin
                            o_cmd.set_res  = 1'b1;
                            o_cmd.res_code = ST_FULL;
                        end else begin
                            o_cmd.rd_free = 1'b1;
                        end
                    end
                    OP_READ, OP_DELETE: begin
                        if (!i_stat.q_valid || i_stat.head_null) begin
                            o_cmd.set_res  = 1'b1;
                            o_cmd.res_code = ST_EMPTY;
                        end else begin
                            o_cmd.rd_head = 1'b1;
                        end
                    end
                    default: begin
                        o_cmd.set_res  = 1'b1;
                        o_cmd.res_code = ST_OK;
                    end
                endcase
            end
            S_RD_WAIT: begin
                o_cmd.set_res     = 1'b1;
                o_cmd.res_code    = ST_OK;
                o_cmd.res_use_key = 1'b1;
            end
            S_DEL_WAIT: begin
                o_cmd.del_commit = 1'b1;
                o_cmd.set_res    = 1'b1;
                o_cmd.res_code   = ST_OK;
            end
            S_ALLOC_WAIT: o_cmd.alloc = 1'b1;
            S_WALK: o_cmd.rd_cur = !i_stat.cur_null;
            S_CMP: o_cmd.step = !i_stat.key_ge;
            S_LINK_NEW: o_cmd.wr_link_n = 1'b1;
            S_LINK_PREV: begin
                o_cmd.link_prev = 1'b1;
                o_cmd.set_res   = 1'b1;
                o_cmd.res_code  = ST_OK;
            end
            S_RESP: o_cmd.out_load = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

/* sv/multi_queue_max_priority_queue.sv */
// ----------------------------------------------------------------------------
// multi_queue_max_priority_queue
// Several max-priority queues kept as sorted linked lists in a shared pool.
// ----------------------------------------------------------------------------
// After reset the block chains the free list through the pool, one entry per
// cycle, and accepts no beat until that is done. Each accepted beat is then
// handled alone and gives one result beat. A read or delete reads the head
// node of the addressed queue, and gives its result without reading the node
// memory when the queue is empty or the index addresses no queue. An insert
// into a valid queue with the pool not full takes an entry from the free list,
// then walks the addressed queue until it stops in front of a stored node or
// at the end of the list, with one registered read of the node memory per node
// that it passes. A result beat held off by the receiver stays in the output
// register, and the next result waits until the held one is taken.
module multi_queue_max_priority_queue import mqpq_pkg::*; #(
    parameter int unsigned NUM_QUEUES   = DefNumQueues,
    parameter int unsigned POOL_ENTRIES = DefPoolEntries
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_operation,
    input  logic [3:0]         i_queue_index,
    input  logic signed [31:0] i_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_max_value
);

    t_cmd  cmd;
    t_stat stat;

    mqpq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    mqpq_datapath #(
        .NUM_QUEUES   (NUM_QUEUES),
        .POOL_ENTRIES (POOL_ENTRIES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_operation   (i_operation),
        .i_queue_index (i_queue_index),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_max_value   (o_max_value)
    );

endmodule
